/* src/grid_maze_dfs_solver_unit_defines.svh */
// Assertion macros shared by the maze solver RTL.
`ifndef GRID_MAZE_DFS_SOLVER_UNIT_DEFINES_SVH
`define GRID_MAZE_DFS_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GMDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gmds: same-cycle check failed");
`define GMDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gmds: next-cycle check failed");
`else
`define GMDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GMDS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/gmds_pkg.sv */
// Shared types and codes of the grid maze depth-first solver.
`timescale 1ns / 1ps
package gmds_pkg;

	localparam int CFG_W = 5;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_SOLVE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_EXIT    = 3'd1;
	localparam logic [2:0] STS_LIMIT   = 3'd2;
	localparam logic [2:0] STS_NO_PATH = 3'd3;
	localparam logic [2:0] STS_RANGE   = 3'd4;

	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_RIGHT = 3'd1;
	localparam logic [2:0] DIR_DOWN  = 3'd2;
	localparam logic [2:0] DIR_LEFT  = 3'd3;
	localparam logic [2:0] DIR_UP    = 3'd4;

	localparam logic [2:0] REG_MAZE_WIDTH      = 3'd0;
	localparam logic [2:0] REG_MAZE_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_ENTRANCE_ROW    = 3'd2;
	localparam logic [2:0] REG_ENTRANCE_COLUMN = 3'd3;
	localparam logic [2:0] REG_EXIT_ROW        = 3'd4;
	localparam logic [2:0] REG_EXIT_COLUMN     = 3'd5;

	typedef struct packed {
		logic [CFG_W-1:0] maze_width;
		logic [CFG_W-1:0] maze_height;
		logic [CFG_W-1:0] entrance_row;
		logic [CFG_W-1:0] entrance_column;
		logic [CFG_W-1:0] exit_row;
		logic [CFG_W-1:0] exit_column;
	} cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] cell_row;
		logic [3:0] cell_column;
		logic       cell_blocked;
		logic [7:0] path_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] path_length;
		logic [3:0] point_row;
		logic [3:0] point_column;
		logic [2:0] point_direction;
	} result_t;

endpackage

/* src/gmds_core.sv */
// Maze map, path stack and the sequencer that walks the maze depth first.
`timescale 1ns / 1ps
`include "grid_maze_dfs_solver_unit_defines.svh"
module gmds_core #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLUMNS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gmds_pkg::cfg_t   cfg,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  gmds_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output gmds_pkg::result_t res
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);
	localparam int EW    = RW + CW + 3;
	localparam int XW    = ((RW > CW) ? RW : CW) + 2;
	localparam int CMPW  = (XW > 6) ? XW : 6;
	localparam int IW    = (CNTW > 8) ? CNTW : 8;
	localparam int LW    = CNTW + 9;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_START  = 4'd2;
	localparam logic [3:0] ST_ITER   = 4'd3;
	localparam logic [3:0] ST_PROBE  = 4'd4;
	localparam logic [3:0] ST_CHECK  = 4'd5;
	localparam logic [3:0] ST_LOAD   = 4'd6;
	localparam logic [3:0] ST_PUSHX  = 4'd7;
	localparam logic [3:0] ST_RDWAIT = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	localparam logic [CNTW-1:0] SC_CELLS = CNTW'(CELLS);

	logic [3:0]      state_q;
	logic [AW-1:0]   clr_q;
	logic [CMPW-1:0] w_q, h_q;
	logic [CNTW-1:0] limit_q, iter_q, sc_q;
	logic [RW-1:0]   cur_row_q, nrow_q;
	logic [CW-1:0]   cur_col_q, ncol_q;
	logic [2:0]      cur_dir_q, dir_q;
	logic [2:0]      res_status_q, res_dir_q;
	logic [3:0]      res_row_q, res_col_q;

	logic            map_mem [CELLS];
	logic            map_rd_q;
	logic            map_we, map_wdata, map_re;
	logic [AW-1:0]   map_waddr, map_raddr;

	logic [EW-1:0]   stk_mem [CELLS];
	logic [EW-1:0]   stk_rd_q;
	logic            stk_we, stk_re;
	logic [EW-1:0]   stk_wdata;
	logic [AW-1:0]   stk_waddr, stk_raddr;

	logic            accept, wr_in_range, rd_in_range, probe_done, pop_go;
	logic            nb_ok, stack_full, exit_hit, iter_left;
	logic [RW-1:0]   nb_row, cmd_row;
	logic [CW-1:0]   nb_col, cmd_col;
	logic [IW-1:0]   idx_w;
	logic [CMPW-1:0] w_sat, h_sat, er_m1, ec_m1;
	logic [2*CMPW-1:0] prod;
	logic [CMPW-1:0] ld_row_w, ld_col_w;
	logic [LW-1:0]   sc_w;
	logic            entrance_bad;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		cell_addr = AW'(r) * AW'(MAX_COLUMNS) + AW'(c);
	endfunction

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = (state_q == ST_DONE);

	assign cmd_row     = CMPW'(cmd.cell_row) < CMPW'(MAX_ROWS) ?
		RW'(CMPW'(cmd.cell_row)) : '0;
	assign cmd_col     = CMPW'(cmd.cell_column) < CMPW'(MAX_COLUMNS) ?
		CW'(CMPW'(cmd.cell_column)) : '0;
	assign wr_in_range = (CMPW'(cmd.cell_row) < CMPW'(MAX_ROWS)) &&
		(CMPW'(cmd.cell_column) < CMPW'(MAX_COLUMNS));
	assign idx_w       = IW'(cmd.path_index);
	assign rd_in_range = idx_w < IW'(sc_q);

	assign w_sat = (CMPW'(cfg.maze_width) > CMPW'(MAX_COLUMNS)) ?
		CMPW'(MAX_COLUMNS) : CMPW'(cfg.maze_width);
	assign h_sat = (CMPW'(cfg.maze_height) > CMPW'(MAX_ROWS)) ?
		CMPW'(MAX_ROWS) : CMPW'(cfg.maze_height);
	assign prod  = (2*CMPW)'(w_q) * (2*CMPW)'(h_q);
	assign er_m1 = CMPW'(cfg.entrance_row) - CMPW'(1);
	assign ec_m1 = CMPW'(cfg.entrance_column) - CMPW'(1);
	assign entrance_bad = (cfg.entrance_row == '0) || (CMPW'(cfg.entrance_row) > h_q) ||
		(cfg.entrance_column == '0) || (CMPW'(cfg.entrance_column) > w_q);

	assign iter_left  = iter_q < limit_q;
	assign probe_done = dir_q > gmds_pkg::DIR_UP;
	assign pop_go     = (state_q == ST_PROBE) && probe_done && (sc_q != '0);
	assign stack_full = sc_q >= SC_CELLS;
	assign exit_hit   = (CMPW'(nrow_q) + CMPW'(1) == CMPW'(cfg.exit_row)) &&
		(CMPW'(ncol_q) + CMPW'(1) == CMPW'(cfg.exit_column));

	// Neighbor of the current cell in the direction under test, and whether it lies in the grid.
	always_comb begin
		nb_row = cur_row_q;
		nb_col = cur_col_q;
		nb_ok  = 1'b0;
		case (dir_q)
			gmds_pkg::DIR_RIGHT: begin
				nb_col = cur_col_q + 1'b1;
				nb_ok  = (CMPW'(cur_col_q) + CMPW'(1)) < w_q;
			end
			gmds_pkg::DIR_DOWN: begin
				nb_row = cur_row_q + 1'b1;
				nb_ok  = (CMPW'(cur_row_q) + CMPW'(1)) < h_q;
			end
			gmds_pkg::DIR_LEFT: begin
				nb_col = cur_col_q - 1'b1;
				nb_ok  = cur_col_q != '0;
			end
			gmds_pkg::DIR_UP: begin
				nb_row = cur_row_q - 1'b1;
				nb_ok  = cur_row_q != '0;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		map_we    = 1'b0;
		map_waddr = cell_addr(cur_row_q, cur_col_q);
		map_wdata = 1'b1;
		map_re    = 1'b0;
		map_raddr = cell_addr(nb_row, nb_col);
		if (state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
			map_wdata = 1'b0;
		end else if (accept && cmd.func == gmds_pkg::FUNC_WRITE && wr_in_range) begin
			map_we    = 1'b1;
			map_waddr = cell_addr(cmd_row, cmd_col);
			map_wdata = cmd.cell_blocked;
		end else if (state_q == ST_ITER && iter_left) begin
			map_we = 1'b1;
		end
		if (state_q == ST_PROBE && !probe_done && nb_ok) begin
			map_re = 1'b1;
		end
	end

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = sc_q[AW-1:0];
		stk_wdata = {cur_row_q, cur_col_q, dir_q};
		stk_re    = 1'b0;
		stk_raddr = idx_w[AW-1:0];
		if (state_q == ST_CHECK && !map_rd_q && !stack_full) begin
			stk_we = 1'b1;
		end else if (state_q == ST_PUSHX) begin
			stk_we    = 1'b1;
			stk_wdata = {cur_row_q, cur_col_q, gmds_pkg::DIR_NONE};
		end
		if (accept && cmd.func == gmds_pkg::FUNC_READ && rd_in_range) begin
			stk_re = 1'b1;
		end else if (pop_go) begin
			stk_re    = 1'b1;
			stk_raddr = AW'(sc_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	assign ld_row_w = CMPW'(stk_rd_q[EW-1 -: RW]);
	assign ld_col_w = CMPW'(stk_rd_q[CW+2 -: CW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			w_q          <= '0;
			h_q          <= '0;
			limit_q      <= '0;
			iter_q       <= '0;
			sc_q         <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_dir_q    <= gmds_pkg::DIR_NONE;
			dir_q        <= gmds_pkg::DIR_NONE;
			nrow_q       <= '0;
			ncol_q       <= '0;
			res_status_q <= gmds_pkg::STS_OK;
			res_row_q    <= '0;
			res_col_q    <= '0;
			res_dir_q    <= gmds_pkg::DIR_NONE;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_status_q <= gmds_pkg::STS_OK;
						res_row_q    <= '0;
						res_col_q    <= '0;
						res_dir_q    <= gmds_pkg::DIR_NONE;
						w_q          <= w_sat;
						h_q          <= h_sat;
						case (cmd.func)
							gmds_pkg::FUNC_SOLVE: begin
								state_q <= ST_START;
							end
							gmds_pkg::FUNC_READ: begin
								if (rd_in_range) begin
									state_q <= ST_RDWAIT;
								end else begin
									res_status_q <= gmds_pkg::STS_RANGE;
									state_q      <= ST_DONE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_START: begin
					limit_q   <= prod[CNTW-1:0];
					sc_q      <= '0;
					iter_q    <= '0;
					cur_row_q <= er_m1[RW-1:0];
					cur_col_q <= ec_m1[CW-1:0];
					cur_dir_q <= gmds_pkg::DIR_NONE;
					if (entrance_bad) begin
						res_status_q <= gmds_pkg::STS_NO_PATH;
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_ITER;
					end
				end
				ST_ITER: begin
					if (!iter_left) begin
						res_status_q <= gmds_pkg::STS_LIMIT;
						state_q      <= ST_DONE;
					end else begin
						// The current cell is marked visited by the map write of this cycle.
						iter_q  <= iter_q + 1'b1;
						dir_q   <= cur_dir_q + 3'd1;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (probe_done) begin
						if (sc_q != '0) begin
							sc_q    <= sc_q - 1'b1;
							state_q <= ST_LOAD;
						end else begin
							res_status_q <= gmds_pkg::STS_NO_PATH;
							state_q      <= ST_DONE;
						end
					end else if (nb_ok) begin
						nrow_q  <= nb_row;
						ncol_q  <= nb_col;
						state_q <= ST_CHECK;
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				ST_CHECK: begin
					if (map_rd_q) begin
						dir_q   <= dir_q + 3'd1;
						state_q <= ST_PROBE;
					end else if (stack_full) begin
						res_status_q <= gmds_pkg::STS_LIMIT;
						state_q      <= ST_DONE;
					end else begin
						sc_q      <= sc_q + 1'b1;
						cur_row_q <= nrow_q;
						cur_col_q <= ncol_q;
						cur_dir_q <= gmds_pkg::DIR_NONE;
						if (!exit_hit) begin
							state_q <= ST_ITER;
						end else if (sc_q + 1'b1 < SC_CELLS) begin
							state_q <= ST_PUSHX;
						end else begin
							res_status_q <= gmds_pkg::STS_EXIT;
							state_q      <= ST_DONE;
						end
					end
				end
				ST_PUSHX: begin
					sc_q         <= sc_q + 1'b1;
					res_status_q <= gmds_pkg::STS_EXIT;
					state_q      <= ST_DONE;
				end
				ST_LOAD: begin
					cur_row_q <= stk_rd_q[EW-1 -: RW];
					cur_col_q <= stk_rd_q[CW+2 -: CW];
					cur_dir_q <= stk_rd_q[2:0];
					state_q   <= ST_ITER;
				end
				ST_RDWAIT: begin
					res_row_q <= ld_row_w[3:0];
					res_col_q <= ld_col_w[3:0];
					res_dir_q <= stk_rd_q[2:0];
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sc_w = LW'(sc_q);

	always_comb begin
		res.status          = res_status_q;
		res.path_length     = sc_w[8:0];
		res.point_row       = res_row_q;
		res.point_column    = res_col_q;
		res.point_direction = res_dir_q;
	end

	`GMDS_ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sc_q <= SC_CELLS)
	`GMDS_ASSERT_IMP(a_no_cmd_in_clear, clk, arst_n, state_q == ST_CLEAR, !cmd_ready)
	`GMDS_ASSERT_NXT(a_push_grows, clk, arst_n, stk_we && state_q == ST_CHECK, sc_q == $past(sc_q) + 1'b1)
	`GMDS_ASSERT_IMP(a_pop_nonempty, clk, arst_n, stk_re && state_q == ST_PROBE, sc_q != '0)
	`GMDS_ASSERT_IMP(a_iter_bound, clk, arst_n, state_q == ST_PROBE, iter_q <= limit_q)

endmodule

/* src/grid_maze_dfs_solver_unit.sv */
// A cell write goes from acceptance straight to ST_DONE and the result register; a path read passes ST_RDWAIT first.
// A solve passes ST_START, then per iteration ST_ITER marks the cell, ST_PROBE tries each
// direction, ST_CHECK follows for each in-grid neighbor looked up, and a pop runs through
// ST_PROBE and ST_LOAD; the single map read port sets this pace. One item is in work at a time.
// After reset a clearing pass over all MAX_ROWS*MAX_COLUMNS map cells opens the whole map
// before the first item is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
module grid_maze_dfs_solver_unit #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLUMNS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cell_row[3:0], cell_column[7:4], cell_blocked[8], path_index[16:9], zero fill
	input  logic [23:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], path_length[11:3], point_row[15:12], point_column[19:16],
	// point_direction[22:20], zero fill
	output logic [23:0] m_axis_tdata
);

	gmds_pkg::cfg_t    cfg_q;
	gmds_pkg::cmd_t    cmd;
	gmds_pkg::result_t res;
	logic              res_valid, res_ready, cfg_wr;
	logic [23:0]       out_data_q;
	logic              out_valid_q;
	logic [4:0]        rd_val;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.maze_width      <= 5'd16;
			cfg_q.maze_height     <= 5'd16;
			cfg_q.entrance_row    <= 5'd1;
			cfg_q.entrance_column <= 5'd1;
			cfg_q.exit_row        <= 5'd16;
			cfg_q.exit_column     <= 5'd16;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				gmds_pkg::REG_MAZE_WIDTH:      cfg_q.maze_width      <= pwdata[4:0];
				gmds_pkg::REG_MAZE_HEIGHT:     cfg_q.maze_height     <= pwdata[4:0];
				gmds_pkg::REG_ENTRANCE_ROW:    cfg_q.entrance_row    <= pwdata[4:0];
				gmds_pkg::REG_ENTRANCE_COLUMN: cfg_q.entrance_column <= pwdata[4:0];
				gmds_pkg::REG_EXIT_ROW:        cfg_q.exit_row        <= pwdata[4:0];
				gmds_pkg::REG_EXIT_COLUMN:     cfg_q.exit_column     <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			gmds_pkg::REG_MAZE_WIDTH:      rd_val = cfg_q.maze_width;
			gmds_pkg::REG_MAZE_HEIGHT:     rd_val = cfg_q.maze_height;
			gmds_pkg::REG_ENTRANCE_ROW:    rd_val = cfg_q.entrance_row;
			gmds_pkg::REG_ENTRANCE_COLUMN: rd_val = cfg_q.entrance_column;
			gmds_pkg::REG_EXIT_ROW:        rd_val = cfg_q.exit_row;
			gmds_pkg::REG_EXIT_COLUMN:     rd_val = cfg_q.exit_column;
			default:                       rd_val = '0;
		endcase
	end

	assign prdata = {27'd0, rd_val};

	assign cmd.func         = s_axis_tuser;
	assign cmd.cell_row     = s_axis_tdata[3:0];
	assign cmd.cell_column  = s_axis_tdata[7:4];
	assign cmd.cell_blocked = s_axis_tdata[8];
	assign cmd.path_index   = s_axis_tdata[16:9];

	gmds_core #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register frees the core as soon as a result is parked here.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {1'b0, res.point_direction, res.point_column, res.point_row,
				res.path_length, res.status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* bench/maze_answer_checker.sv */
// Checker for the maze solver: watches all channels, predicts each answer and compares it.
`timescale 1ns / 1ps
module maze_answer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// cell_row[3:0], cell_column[7:4], cell_blocked[8], path_index[16:9], zero fill
	input  logic [23:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], path_length[11:3], point_row[15:12], point_column[19:16],
	// point_direction[22:20], zero fill
	input  logic [23:0] m_axis_tdata,
	output int          mismatches,
	output int          pending
);

	localparam int SIDE = 16;
	localparam int CELLS = SIDE * SIDE;
	localparam int SLOTS = 16;

	bit                walls [CELLS];
	logic [3:0]        trail_row [CELLS];
	logic [3:0]        trail_col [CELLS];
	logic [2:0]        trail_dir [CELLS];
	int                depth;
	logic [4:0]        width_reg, height_reg, in_row, in_col, out_row, out_col;
	gmds_pkg::result_t answers [SLOTS];
	int                head, tail;
	int                taken;

	// Depth-first walk from the entrance; returns the status and leaves the path in the trail.
	function automatic logic [2:0] walk_maze();
		int w, h, lim, iter, d, cur_r, cur_c, cur_d, next_r, next_c, found;
		bit ok;
		w = (width_reg > SIDE) ? SIDE : int'(width_reg);
		h = (height_reg > SIDE) ? SIDE : int'(height_reg);
		lim = w * h;
		depth = 0;
		if (in_row < 1 || in_row > h || in_col < 1 || in_col > w)
			return gmds_pkg::STS_NO_PATH;
		cur_r = int'(in_row) - 1;
		cur_c = int'(in_col) - 1;
		cur_d = int'(gmds_pkg::DIR_NONE);
		iter = 0;
		while (iter < lim) begin
			iter++;
			walls[cur_r * SIDE + cur_c] = 1'b1;
			found = int'(gmds_pkg::DIR_NONE);
			next_r = cur_r;
			next_c = cur_c;
			for (d = cur_d + 1; d <= int'(gmds_pkg::DIR_UP); d++) begin
				if (found == int'(gmds_pkg::DIR_NONE)) begin
					case (d)
						gmds_pkg::DIR_RIGHT: ok = (cur_c + 1 < w);
						gmds_pkg::DIR_DOWN:  ok = (cur_r + 1 < h);
						gmds_pkg::DIR_LEFT:  ok = (cur_c > 0);
						default:             ok = (cur_r > 0);
					endcase
					if (ok) begin
						next_r = cur_r + int'(d == gmds_pkg::DIR_DOWN) -
							int'(d == gmds_pkg::DIR_UP);
						next_c = cur_c + int'(d == gmds_pkg::DIR_RIGHT) -
							int'(d == gmds_pkg::DIR_LEFT);
						if (!walls[next_r * SIDE + next_c])
							found = d;
					end
				end
			end
			if (found != int'(gmds_pkg::DIR_NONE)) begin
				if (depth >= CELLS)
					return gmds_pkg::STS_LIMIT;
				trail_row[depth] = 4'(cur_r);
				trail_col[depth] = 4'(cur_c);
				trail_dir[depth] = 3'(found);
				depth++;
				cur_r = next_r;
				cur_c = next_c;
				cur_d = int'(gmds_pkg::DIR_NONE);
				if (next_r + 1 == out_row && next_c + 1 == out_col) begin
					if (depth < CELLS) begin
						trail_row[depth] = 4'(next_r);
						trail_col[depth] = 4'(next_c);
						trail_dir[depth] = gmds_pkg::DIR_NONE;
						depth++;
					end
					return gmds_pkg::STS_EXIT;
				end
			end else if (depth > 0) begin
				// Back up one step and resume with the direction after the one taken.
				depth--;
				cur_r = int'(trail_row[depth]);
				cur_c = int'(trail_col[depth]);
				cur_d = int'(trail_dir[depth]);
			end else begin
				return gmds_pkg::STS_NO_PATH;
			end
		end
		return gmds_pkg::STS_LIMIT;
	endfunction

	function automatic gmds_pkg::result_t answer_for(input logic [1:0] func,
			input logic [23:0] data);
		gmds_pkg::result_t res;
		logic [7:0] index;
		res = '0;
		index = data[16:9];
		case (func)
			gmds_pkg::FUNC_WRITE: walls[{data[3:0], data[7:4]}] = data[8];
			gmds_pkg::FUNC_SOLVE: res.status = walk_maze();
			gmds_pkg::FUNC_READ: begin
				if (index < depth) begin
					res.point_row = trail_row[index];
					res.point_column = trail_col[index];
					res.point_direction = trail_dir[index];
				end else begin
					res.status = gmds_pkg::STS_RANGE;
				end
			end
			default: ;
		endcase
		res.path_length = 9'(depth);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gmds_pkg::result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				walls[i] = 1'b0;
			depth = 0;
			width_reg = 5'd16;
			height_reg = 5'd16;
			in_row = 5'd1;
			in_col = 5'd1;
			out_row = 5'd16;
			out_col = 5'd16;
			head = 0;
			tail = 0;
			mismatches = 0;
			pending = 0;
			taken = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					gmds_pkg::REG_MAZE_WIDTH:      width_reg = pwdata[4:0];
					gmds_pkg::REG_MAZE_HEIGHT:     height_reg = pwdata[4:0];
					gmds_pkg::REG_ENTRANCE_ROW:    in_row = pwdata[4:0];
					gmds_pkg::REG_ENTRANCE_COLUMN: in_col = pwdata[4:0];
					gmds_pkg::REG_EXIT_ROW:        out_row = pwdata[4:0];
					gmds_pkg::REG_EXIT_COLUMN:     out_col = pwdata[4:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				answers[tail % SLOTS] = answer_for(s_axis_tuser, s_axis_tdata);
				tail++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[2:0];
				got.path_length = m_axis_tdata[11:3];
				got.point_row = m_axis_tdata[15:12];
				got.point_column = m_axis_tdata[19:16];
				got.point_direction = m_axis_tdata[22:20];
				if (head == tail) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no transaction waiting: data %h",
							taken, m_axis_tdata);
				end else begin
					want = answers[head % SLOTS];
					head++;
					if (got.status !== want.status || got.path_length !== want.path_length ||
							got.point_row !== want.point_row ||
							got.point_column !== want.point_column ||
							got.point_direction !== want.point_direction) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d expected status %0d length %0d row %0d column %0d direction %0d",
								taken, want.status, want.path_length, want.point_row,
								want.point_column, want.point_direction);
							$display("result %0d got status %0d length %0d row %0d column %0d direction %0d",
								taken, got.status, got.path_length, got.point_row,
								got.point_column, got.point_direction);
						end
					end
				end
				taken++;
			end
			pending = tail - head;
		end
	end

endmodule

/* bench/testbench.sv */
// Top of the maze solver bench: clock, reset, stimulus, receiver back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 555;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	int          mismatches;
	int          pending;
	int          items_sent = 0;
	int          results_taken = 0;
	int          cycles = 0;
	int          stall_left = 0;
	bit          long_hold_done = 1'b0;

	grid_maze_dfs_solver_unit uut (.*);
	maze_answer_checker answer_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (m_axis_tvalid && m_axis_tready)
			results_taken <= results_taken + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, a quiet window, and one long hold-off while the sender keeps going.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!long_hold_done && results_taken >= 60 && s_axis_tvalid) begin
			long_hold_done <= 1'b1;
			stall_left <= 300;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (results_taken >= 250 && results_taken < 350) ||
				$urandom_range(99) >= 19;
		end
	end

	task automatic put_reg(input logic [2:0] which, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic issue(input logic [1:0] func, input logic [3:0] row, input logic [3:0] col,
			input logic blk, input logic [7:0] index);
		@(negedge clk);
		while (!(items_sent >= 200 && items_sent < 320) && $urandom_range(99) < 19) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {7'd0, index, blk, col, row};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Sends a transaction whose fields besides the function are random.
	task automatic issue_random(input logic [1:0] func);
		logic [31:0] noise;
		noise = $urandom;
		issue(func, noise[3:0], noise[7:4], noise[8], noise[16:9]);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input int er, input int ec,
			input int xr, input int xc);
		drain();
		put_reg(gmds_pkg::REG_MAZE_WIDTH, w);
		put_reg(gmds_pkg::REG_MAZE_HEIGHT, h);
		put_reg(gmds_pkg::REG_ENTRANCE_ROW, er);
		put_reg(gmds_pkg::REG_ENTRANCE_COLUMN, ec);
		put_reg(gmds_pkg::REG_EXIT_ROW, xr);
		put_reg(gmds_pkg::REG_EXIT_COLUMN, xc);
	endtask

	initial begin
		int w, h, ew, eh, er, ec, xr, xc, span, target;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default geometry: full 16 by 16 grid, entrance top left, exit bottom right.
		issue(gmds_pkg::FUNC_WRITE, 4'd15, 4'd15, 1'b0, 8'hFF);
		issue(gmds_pkg::FUNC_WRITE, 4'd0, 4'd0, 1'b0, 8'h00);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'h00);
		issue(gmds_pkg::FUNC_READ, 4'hF, 4'hF, 1'b1, 8'd0);
		issue(gmds_pkg::FUNC_READ, 4'd0, 4'd0, 1'b0, 8'd30);
		issue(gmds_pkg::FUNC_READ, 4'd0, 4'd0, 1'b0, 8'd31);
		issue(gmds_pkg::FUNC_READ, 4'd0, 4'd0, 1'b0, 8'd255);
		issue(FUNC_SPARE, 4'hF, 4'hF, 1'b1, 8'hFF);
		// The second walk runs into the cells the first one left blocked.
		issue(gmds_pkg::FUNC_SOLVE, 4'hF, 4'hF, 1'b1, 8'hFF);

		// Oversized grid saturates; an entrance on row zero gives up at once.
		configure(31, 31, 0, 1, 16, 16);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_READ, 4'd0, 4'd0, 1'b0, 8'd0);
		// Entrance below the rows in use.
		configure(3, 2, 3, 1, 2, 3);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);
		// Empty grid.
		configure(0, 0, 1, 1, 1, 1);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);
		// Exit on the entrance: the walk covers the whole grid and runs out of iterations.
		configure(2, 2, 1, 1, 1, 1);
		issue(gmds_pkg::FUNC_WRITE, 4'd0, 4'd0, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_WRITE, 4'd0, 4'd1, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_WRITE, 4'd1, 4'd0, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_WRITE, 4'd1, 4'd1, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_READ, 4'd0, 4'd0, 1'b0, 8'd3);
		// A single cell is a dead end with nothing to pop.
		configure(1, 1, 1, 1, 16, 16);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);
		// Exit beyond the grid and a wall across a single row: back up, then give up.
		configure(4, 1, 1, 1, 1, 31);
		issue(gmds_pkg::FUNC_WRITE, 4'd0, 4'd2, 1'b1, 8'd0);
		issue(gmds_pkg::FUNC_WRITE, 4'd0, 4'd1, 1'b0, 8'd0);
		issue(gmds_pkg::FUNC_SOLVE, 4'd0, 4'd0, 1'b0, 8'd0);

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			// Mostly small grids keep the walks short; now and then a large one.
			if ($urandom_range(7) == 0) begin
				w = $urandom_range(16, 12);
				h = $urandom_range(16, 12);
			end else begin
				w = $urandom_range(6, 1);
				h = $urandom_range(6, 1);
			end
			if ($urandom_range(9) == 0)
				w = $urandom_range(31);
			if ($urandom_range(9) == 0)
				h = $urandom_range(31);
			ew = (w > 16) ? 16 : w;
			eh = (h > 16) ? 16 : h;
			er = $urandom_range((eh > 0) ? eh : 1, 1);
			ec = $urandom_range((ew > 0) ? ew : 1, 1);
			if ($urandom_range(9) == 0)
				er = $urandom_range(31);
			if ($urandom_range(9) == 0)
				ec = $urandom_range(31);
			xr = $urandom_range((eh > 0) ? eh : 1, 1);
			xc = $urandom_range((ew > 0) ? ew : 1, 1);
			if ($urandom_range(7) == 0) begin
				xr = $urandom_range(31);
				xc = $urandom_range(31);
			end
			configure(w, h, er, ec, xr, xc);

			span = ew * eh;
			if (span <= 36) begin
				for (int r = 0; r < eh; r++)
					for (int c = 0; c < ew; c++)
						issue(gmds_pkg::FUNC_WRITE, 4'(r), 4'(c),
							!(r == er - 1 && c == ec - 1) && $urandom_range(99) < 28,
							8'($urandom));
			end else begin
				for (int k = 0; k < 40; k++)
					issue(gmds_pkg::FUNC_WRITE, 4'($urandom_range(eh - 1)),
						4'($urandom_range(ew - 1)), $urandom_range(99) < 15,
						8'($urandom));
				issue(gmds_pkg::FUNC_WRITE, 4'(er - 1), 4'(ec - 1), 1'b0, 8'($urandom));
			end
			if ($urandom_range(3) == 0) begin
				if ($urandom_range(1) == 0)
					issue_random(FUNC_SPARE);
				else
					issue_random(gmds_pkg::FUNC_WRITE);
			end

			issue_random(gmds_pkg::FUNC_SOLVE);
			if ($urandom_range(4) == 0)
				issue_random(gmds_pkg::FUNC_SOLVE);
			repeat ($urandom_range(5, 1)) begin
				if ($urandom_range(3) != 0)
					issue(gmds_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 1'($urandom),
						8'($urandom_range((span > 255) ? 255 : span)));
				else
					issue(gmds_pkg::FUNC_READ, 4'($urandom), 4'($urandom), 1'($urandom),
						8'($urandom_range(255)));
			end
		end

		drain();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
